### rtl/alm_pkg.sv
// Shared types and constants for the audio level meter.
// Holds the item structs, command codes and register indexes.
// No dependencies.
package alm_pkg;

	localparam int LEVEL_BITS = 16;
	localparam int AGE_BITS   = 16;
	localparam int COUNT_BITS = 10;
	localparam int CMD_BITS   = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CMD_BITS-1:0] CMD_LEVEL = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTH_COEFF    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_PER_TICK  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TICKS      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REDRAW_INTERVAL = 2'd3;

	localparam logic [LEVEL_BITS-1:0] SMOOTH_COEFF_RST    = 16'd58982;
	localparam logic [LEVEL_BITS-1:0] DECAY_PER_TICK_RST  = 16'd66;
	localparam logic [AGE_BITS-1:0]   HOLD_TICKS_RST      = 16'd2000;
	localparam logic [COUNT_BITS-1:0] REDRAW_INTERVAL_RST = 10'd50;

	typedef struct packed {
		logic [CMD_BITS-1:0]   command;
		logic [LEVEL_BITS-1:0] rms_in;
		logic [LEVEL_BITS-1:0] peak_in;
	} meter_in_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] rms_level;
		logic [LEVEL_BITS-1:0] peak_level;
		logic [LEVEL_BITS-1:0] decayed_peak;
		logic [LEVEL_BITS-1:0] hold_level;
	} meter_out_t;

endpackage

### rtl/audio_level_peak_hold_meter.sv
// Level meter core: RMS smoothing, peak capture with linear decay, peak hold.
// Depends on alm_pkg for the item structs, command codes and register indexes.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------
//  in      | input     | in_valid / in_ready  | in_data  (meter_in_t)
//  out     | output    | out_valid / out_ready| out_data (meter_out_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready holds; each item passes from acceptance
// through the input register and then the result register.
// The state update and the result are computed in a single pass from the input register;
// the RMS multiplier and the decay multiplier set the path length.
// A stalled result register holds the input register; the input side stalls only then.
// Reset clears all levels, ages and counters and loads the register defaults.
module audio_level_peak_hold_meter
	import alm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  meter_in_t                in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output meter_out_t               out_data,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// Configuration registers.
	logic [LEVEL_BITS-1:0] smooth_coeff_q;
	logic [LEVEL_BITS-1:0] decay_per_tick_q;
	logic [AGE_BITS-1:0]   hold_ticks_q;
	logic [COUNT_BITS-1:0] redraw_interval_q;

	// Meter state.
	logic [LEVEL_BITS-1:0] rms_acc_q;
	logic [LEVEL_BITS-1:0] peak_q;
	logic [LEVEL_BITS-1:0] decayed_q;
	logic [LEVEL_BITS-1:0] hold_q;
	logic [AGE_BITS-1:0]   peak_age_q;
	logic [AGE_BITS-1:0]   hold_age_q;
	logic [COUNT_BITS-1:0] redraw_count_q;

	// Pipeline.
	meter_in_t  in_s1;
	logic       valid_s1;
	meter_out_t out_s2;
	logic       valid_s2;
	logic       advance;

	// Next-state values.
	logic [LEVEL_BITS-1:0] rms_acc_nx;
	logic [LEVEL_BITS-1:0] peak_nx;
	logic [LEVEL_BITS-1:0] decayed_nx;
	logic [LEVEL_BITS-1:0] hold_nx;
	logic [AGE_BITS-1:0]   peak_age_nx;
	logic [AGE_BITS-1:0]   hold_age_nx;
	logic [COUNT_BITS-1:0] redraw_count_nx;

	// Datapath terms.
	logic signed [LEVEL_BITS:0]       rms_diff;
	logic signed [LEVEL_BITS:0]       coeff_s;
	logic signed [2*LEVEL_BITS+1:0]   rms_prod;
	logic signed [2*LEVEL_BITS+1:0]   rms_sum;
	logic [AGE_BITS-1:0]              peak_age_inc;
	logic [AGE_BITS-1:0]              hold_age_inc;
	logic [2*LEVEL_BITS-1:0]          drop;
	logic [COUNT_BITS-1:0]            count_inc;
	logic [COUNT_BITS-1:0]            limit;
	logic                             redraw_due;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	// rms*c + in*(1-c) is rewritten as in*1 + (rms-in)*c to use one multiplier.
	assign rms_diff = $signed({1'b0, rms_acc_q}) - $signed({1'b0, in_s1.rms_in});
	assign coeff_s  = $signed({1'b0, smooth_coeff_q});
	assign rms_prod = rms_diff * coeff_s;
	assign rms_sum  = rms_prod + $signed({2'b00, in_s1.rms_in, {LEVEL_BITS{1'b0}}});

	assign peak_age_inc = (peak_age_q == {AGE_BITS{1'b1}}) ? peak_age_q : peak_age_q + 1'b1;
	assign hold_age_inc = (hold_age_q == {AGE_BITS{1'b1}}) ? hold_age_q : hold_age_q + 1'b1;
	assign drop         = decay_per_tick_q * peak_age_inc;

	assign count_inc  = redraw_count_q + 1'b1;
	assign limit      = (redraw_interval_q == '0) ? COUNT_BITS'(1) : redraw_interval_q;
	// A count that wraps to zero also triggers an evaluation.
	assign redraw_due = (count_inc >= limit) || (count_inc == '0);

	always_comb begin
		rms_acc_nx      = rms_acc_q;
		peak_nx         = peak_q;
		decayed_nx      = decayed_q;
		hold_nx         = hold_q;
		peak_age_nx     = peak_age_q;
		hold_age_nx     = hold_age_q;
		redraw_count_nx = redraw_count_q;
		case (in_s1.command)
			CMD_LEVEL: begin
				rms_acc_nx = rms_sum[2*LEVEL_BITS-1:LEVEL_BITS];
				if (in_s1.peak_in > decayed_q) begin
					peak_nx     = in_s1.peak_in;
					decayed_nx  = in_s1.peak_in;
					peak_age_nx = '0;
				end
				if (in_s1.peak_in > hold_q) begin
					hold_nx     = in_s1.peak_in;
					hold_age_nx = '0;
				end
			end
			CMD_TICK: begin
				peak_age_nx     = peak_age_inc;
				hold_age_nx     = hold_age_inc;
				redraw_count_nx = count_inc;
				if (redraw_due) begin
					redraw_count_nx = '0;
					if (drop < {{LEVEL_BITS{1'b0}}, peak_q}) begin
						decayed_nx = peak_q - drop[LEVEL_BITS-1:0];
					end else begin
						decayed_nx = '0;
					end
					if (hold_age_inc > hold_ticks_q) begin
						hold_nx = '0;
					end
				end
			end
			CMD_CLEAR: begin
				rms_acc_nx = '0;
				peak_nx    = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_coeff_q    <= SMOOTH_COEFF_RST;
			decay_per_tick_q  <= DECAY_PER_TICK_RST;
			hold_ticks_q      <= HOLD_TICKS_RST;
			redraw_interval_q <= REDRAW_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SMOOTH_COEFF:    smooth_coeff_q    <= cfg_data[LEVEL_BITS-1:0];
				CFG_DECAY_PER_TICK:  decay_per_tick_q  <= cfg_data[LEVEL_BITS-1:0];
				CFG_HOLD_TICKS:      hold_ticks_q      <= cfg_data[AGE_BITS-1:0];
				CFG_REDRAW_INTERVAL: redraw_interval_q <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rms_acc_q      <= '0;
			peak_q         <= '0;
			decayed_q      <= '0;
			hold_q         <= '0;
			peak_age_q     <= '0;
			hold_age_q     <= '0;
			redraw_count_q <= '0;
		end else if (advance) begin
			rms_acc_q      <= rms_acc_nx;
			peak_q         <= peak_nx;
			decayed_q      <= decayed_nx;
			hold_q         <= hold_nx;
			peak_age_q     <= peak_age_nx;
			hold_age_q     <= hold_age_nx;
			redraw_count_q <= redraw_count_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (advance) begin
			out_s2.rms_level    <= rms_acc_nx;
			out_s2.peak_level   <= peak_nx;
			out_s2.decayed_peak <= decayed_nx;
			out_s2.hold_level   <= hold_nx;
		end
	end

	// An empty result register never stalls the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with an empty result register");

	// A clear item shows zero RMS and peak in its result.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_s1.command == CMD_CLEAR) |=>
		(out_s2.rms_level == '0 && out_s2.peak_level == '0))
		else $error("clear item did not zero the levels");

	// Age counters never move backward on a tick.
	a_tick_age: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_s1.command == CMD_TICK) |=>
		(peak_age_q >= $past(peak_age_q) && hold_age_q >= $past(hold_age_q)))
		else $error("age counter decreased on a tick");

	// The redraw counter stays below its limit after a tick unless the limit changed.
	a_redraw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_s1.command == CMD_TICK && !cfg_we) |=> (redraw_count_q < limit))
		else $error("redraw counter passed its interval");

endmodule
